// ----- design/ufr_pkg.sv -----
// Shared types, constants and helpers for the streaming find-and-replace block.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ufr_pkg;

  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;
  localparam int REG_LSB = 3;
  localparam int LEN_W   = 5;
  localparam int RC_W    = 24;

  // lead-byte thresholds that set the number of continuation bytes
  localparam logic [7:0] LEAD_MIN = 8'd128;
  localparam logic [7:0] LEAD_2   = 8'd192;
  localparam logic [7:0] LEAD_3   = 8'd224;
  localparam logic [7:0] LEAD_4   = 8'd240;
  localparam logic [7:0] LEAD_5   = 8'd248;
  localparam logic [7:0] LEAD_6   = 8'd252;

  typedef enum logic [2:0] {
    REG_PAT_LO  = 3'd0,
    REG_PAT_HI  = 3'd1,
    REG_PAT_LEN = 3'd2,
    REG_REP_LO  = 3'd3,
    REG_REP_HI  = 3'd4,
    REG_REP_LEN = 3'd5
  } ufr_reg_t;

  typedef struct packed {
    logic [63:0]      pat_lo;
    logic [63:0]      pat_hi;
    logic [LEN_W-1:0] pat_len;
    logic [63:0]      rep_lo;
    logic [63:0]      rep_hi;
    logic [LEN_W-1:0] rep_len;
  } ufr_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ufr_qstat_t;

  function automatic logic [2:0] cont_count(input logic [7:0] b);
    logic [2:0] c;
    c = 3'd0;
    if (b >= LEAD_MIN) begin
      if (b >= LEAD_2) c = c + 3'd1;
      if (b >= LEAD_3) c = c + 3'd1;
      if (b >= LEAD_4) c = c + 3'd1;
      if (b >= LEAD_5) c = c + 3'd1;
      if (b >= LEAD_6) c = c + 3'd1;
    end
    return c;
  endfunction

  // byte idx of a 16-byte string held as two 64-bit words; zero past the end
  function automatic logic [7:0] byte_of(input logic [63:0] lo, input logic [63:0] hi,
                                         input int idx);
    logic [7:0] r;
    r = 8'h00;
    if (idx >= 0 && idx < 8) begin
      r = lo[idx*8 +: 8];
    end else if (idx >= 8 && idx < 16) begin
      r = hi[(idx-8)*8 +: 8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/ufr_regs.sv -----
// APB-style configuration registers: pattern, replacement and their lengths.
// Depends on ufr_pkg (register map, ufr_cfg_t).
`timescale 1ns / 1ps
`default_nettype none

module ufr_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ufr_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ufr_pkg::PDATA_W-1:0]   pwdata,
  output logic      [ufr_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output ufr_pkg::ufr_cfg_t                  cfg
);

  ufr_pkg::ufr_cfg_t cfg_r, cfg_nxt;
  ufr_pkg::ufr_reg_t sel;

  assign sel    = ufr_pkg::ufr_reg_t'(paddr[ufr_pkg::PADDR_W-1:ufr_pkg::REG_LSB]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (sel)
        ufr_pkg::REG_PAT_LO:  cfg_nxt.pat_lo  = pwdata;
        ufr_pkg::REG_PAT_HI:  cfg_nxt.pat_hi  = pwdata;
        ufr_pkg::REG_PAT_LEN: cfg_nxt.pat_len = pwdata[ufr_pkg::LEN_W-1:0];
        ufr_pkg::REG_REP_LO:  cfg_nxt.rep_lo  = pwdata;
        ufr_pkg::REG_REP_HI:  cfg_nxt.rep_hi  = pwdata;
        ufr_pkg::REG_REP_LEN: cfg_nxt.rep_len = pwdata[ufr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      ufr_pkg::REG_PAT_LO:  prdata = cfg_r.pat_lo;
      ufr_pkg::REG_PAT_HI:  prdata = cfg_r.pat_hi;
      ufr_pkg::REG_PAT_LEN: prdata = {{(ufr_pkg::PDATA_W-ufr_pkg::LEN_W){1'b0}},
                                      cfg_r.pat_len};
      ufr_pkg::REG_REP_LO:  prdata = cfg_r.rep_lo;
      ufr_pkg::REG_REP_HI:  prdata = cfg_r.rep_hi;
      ufr_pkg::REG_REP_LEN: prdata = {{(ufr_pkg::PDATA_W-ufr_pkg::LEN_W){1'b0}},
                                      cfg_r.rep_len};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/ufr_front.sv -----
// Front end: takes one text beat per cycle unless stalled, keeps the lookahead window,
// compares it to the pattern, turning each beat into at most one command. Depends on ufr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ufr_front #(
  parameter int MAX_PATTERN     = 16,
  parameter int MAX_REPLACEMENT = 16,
  parameter int COUNT_BITS      = 24,
  localparam int NB   = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT,
  localparam int NW   = $clog2(NB + 1),
  localparam int CMDW = 1 + COUNT_BITS + NW + NB*8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_take,
  input  wire logic [7:0]      in_text_byte,
  input  wire logic            in_end_of_text,
  input  wire ufr_pkg::ufr_cfg_t cfg,
  output logic                 cmd_push,
  output logic [CMDW-1:0]      cmd_data
);

  localparam int FW = $clog2(MAX_PATTERN + 1);
  localparam int RW = $clog2(MAX_REPLACEMENT + 1);

  logic [7:0]            win_r   [MAX_PATTERN];
  logic [7:0]            win_nxt [MAX_PATTERN];
  logic [7:0]            win_ext [MAX_PATTERN];
  logic [FW-1:0]         fill_r, fill_nxt, fill_inc;
  logic [2:0]            pt_r, pt_nxt;
  logic [COUNT_BITS-1:0] tally_r, tally_nxt;
  ufr_pkg::ufr_cfg_t     act_r, act_nxt, eff;
  logic [FW-1:0]         pat_len;
  logic [RW-1:0]         rep_len;
  logic [MAX_PATTERN-1:0] pos_ok;
  logic                  hit, full_win;
  logic [2:0]            lead_cont, k;
  logic [7:0]            pay [NB];
  logic [NB*8-1:0]       pay_flat;
  logic [NW-1:0]         cnt;
  logic                  term;

  // config registers are taken up whenever a beat arrives to an empty window
  assign eff = (fill_r == '0) ? cfg : act_r;

  assign pat_len = (int'(eff.pat_len) > MAX_PATTERN) ? FW'(MAX_PATTERN) : FW'(eff.pat_len);
  assign rep_len = (int'(eff.rep_len) > MAX_REPLACEMENT) ? RW'(MAX_REPLACEMENT)
                                                          : RW'(eff.rep_len);

  assign fill_inc = fill_r + FW'(1);
  assign full_win = (fill_inc >= pat_len);

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_ext[i] = (fill_r == FW'(i)) ? in_text_byte : win_r[i];
      pos_ok[i]  = (FW'(i) >= pat_len) ||
                   (win_ext[i] == ufr_pkg::byte_of(eff.pat_lo, eff.pat_hi, i));
    end
  end

  assign hit       = (pat_len != '0) && (&pos_ok);
  assign lead_cont = ufr_pkg::cont_count(win_ext[0]);
  // continuation bytes that are already in the window go out with the lead byte
  assign k         = (int'(fill_r) < int'(lead_cont)) ? 3'(fill_r) : lead_cont;

  always_comb begin
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    pt_nxt    = pt_r;
    tally_nxt = tally_r;
    act_nxt   = act_r;
    cmd_push  = 1'b0;
    term      = 1'b0;
    cnt       = '0;
    for (int j = 0; j < NB; j++) begin
      pay[j] = 8'h00;
    end
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pay[j] = win_ext[j];
    end
    if (item_take) begin
      if (fill_r == '0) begin
        act_nxt = cfg;
      end
      if (in_end_of_text) begin
        // flush what the window holds, then the terminator
        cmd_push  = 1'b1;
        term      = 1'b1;
        cnt       = NW'(fill_r);
        fill_nxt  = '0;
        pt_nxt    = 3'd0;
        tally_nxt = '0;
      end else if (pt_r != 3'd0 && fill_r == '0) begin
        cmd_push = 1'b1;
        cnt      = NW'(1);
        pt_nxt   = pt_r - 3'd1;
      end else if (!full_win) begin
        win_nxt  = win_ext;
        fill_nxt = fill_inc;
      end else if (hit) begin
        cmd_push = (rep_len != '0);
        cnt      = NW'(rep_len);
        for (int j = 0; j < NB; j++) begin
          pay[j] = ufr_pkg::byte_of(eff.rep_lo, eff.rep_hi, j);
        end
        fill_nxt = '0;
        if (tally_r != '1) begin
          tally_nxt = tally_r + COUNT_BITS'(1);
        end
      end else begin
        cmd_push = 1'b1;
        cnt      = NW'(k) + NW'(1);
        pt_nxt   = lead_cont - k;
        fill_nxt = fill_r - FW'(k);
        for (int j = 0; j < MAX_PATTERN; j++) begin
          for (int s = 1; s <= 6; s++) begin
            if (int'(k) + 1 == s && j + s < MAX_PATTERN) begin
              win_nxt[j] = win_ext[(j + s < MAX_PATTERN) ? j + s : 0];
            end
          end
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      pay_flat[j*8 +: 8] = pay[j];
    end
  end

  assign cmd_data = {term, tally_r, cnt, pay_flat};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      pt_r    <= 3'd0;
      tally_r <= '0;
      act_r   <= '0;
    end else begin
      fill_r  <= fill_nxt;
      pt_r    <= pt_nxt;
      tally_r <= tally_nxt;
      act_r   <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

`default_nettype wire

// ----- design/ufr_cmd_fifo.sv -----
// Two-entry command queue between the front end and the back end.
// Depends on ufr_pkg (ufr_qstat_t).
`timescale 1ns / 1ps
`default_nettype none

module ufr_cmd_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head,
  output ufr_pkg::ufr_qstat_t   stat
);

  localparam int DEPTH = 2;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic             wr_r, rd_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_r <= !wr_r;
      if (do_pop)  rd_r <= !rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- design/ufr_back.sv -----
// Back end: expands the command at the queue head into result beats, one per cycle
// while the output register they go into is empty or popped. Depends on ufr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ufr_back #(
  parameter int MAX_PATTERN     = 16,
  parameter int MAX_REPLACEMENT = 16,
  parameter int COUNT_BITS      = 24,
  localparam int NB   = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT,
  localparam int NW   = $clog2(NB + 1),
  localparam int CMDW = 1 + COUNT_BITS + NW + NB*8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [CMDW-1:0]             head,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  output logic [7:0]                       out_byte,
  output logic                             out_is_terminator,
  output logic                             out_last,
  output logic [ufr_pkg::RC_W-1:0]         out_replace_count,
  output logic                             empty,
  input  wire logic                        pop
);

  localparam int SW = (NB > 1) ? $clog2(NB) : 1;

  logic                    h_term;
  logic [COUNT_BITS-1:0]   h_tally;
  logic [NW-1:0]           h_cnt;
  logic [7:0]              hb [NB];
  logic [31:0]             tally_ext;
  logic [NW:0]             elem_cnt;
  logic [NW-1:0]           idx_r;
  logic                    is_byte, is_last, load;
  logic                    out_valid_r;
  logic [7:0]              out_byte_r;
  logic                    out_term_r, out_last_r;
  logic [ufr_pkg::RC_W-1:0] out_cnt_r;

  assign h_term  = head[CMDW-1];
  assign h_tally = head[CMDW-2 -: COUNT_BITS];
  assign h_cnt   = head[NB*8 +: NW];

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      hb[j] = head[j*8 +: 8];
    end
  end

  assign tally_ext = 32'(h_tally);
  // a command is its bytes followed by the terminator, if it carries one
  assign elem_cnt  = {1'b0, h_cnt} + (NW+1)'(h_term);
  assign is_byte   = (idx_r < h_cnt);
  assign is_last   = ({1'b0, idx_r} + (NW+1)'(1) == elem_cnt);
  assign load      = !q_empty && (!out_valid_r || pop);
  assign q_pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? '0 : idx_r + NW'(1);
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= is_byte ? hb[idx_r[SW-1:0]] : 8'h00;
      out_term_r <= !is_byte;
      out_last_r <= is_last;
      out_cnt_r  <= is_byte ? '0 : tally_ext[ufr_pkg::RC_W-1:0];
    end
  end

  assign empty             = !out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_is_terminator = out_term_r;
  assign out_last          = out_last_r;
  assign out_replace_count = out_cnt_r;

endmodule

`default_nettype wire

// ----- design/utf8_find_and_replace.sv -----
// Streaming find-and-replace: one text byte accepted per cycle while the command queue
// has room; an item holds the back end until all its results are out, and the front
// stalls only once the 2-entry queue fills.
// Each command is queued, then its results reach the ports via the output register.
// Synchronous active-low reset clears window fill, continuation count, tally, queue and
// output valid; configuration registers reset to zero.
`timescale 1ns / 1ps
`default_nettype none

module utf8_find_and_replace #(
  parameter int MAX_PATTERN     = 16,
  parameter int MAX_REPLACEMENT = 16,
  parameter int COUNT_BITS      = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ufr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [ufr_pkg::PDATA_W-1:0] pwdata,
  output logic      [ufr_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [7:0]                  in_text_byte,
  input  wire logic                        in_end_of_text,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [7:0]                       out_byte,
  output logic                             out_is_terminator,
  output logic                             out_last,
  output logic [ufr_pkg::RC_W-1:0]         out_replace_count
);

  localparam int NB   = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int NW   = $clog2(NB + 1);
  localparam int CMDW = 1 + COUNT_BITS + NW + NB*8;

  ufr_pkg::ufr_cfg_t   cfg;
  ufr_pkg::ufr_qstat_t qstat;
  logic                item_take;
  logic                cmd_push, cmd_pop;
  logic [CMDW-1:0]     cmd_data, cmd_head;

  assign full      = qstat.full;
  assign item_take = push && !qstat.full;

  ufr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ufr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT),
    .COUNT_BITS      (COUNT_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_take      (item_take),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .cfg            (cfg),
    .cmd_push       (cmd_push),
    .cmd_data       (cmd_data)
  );

  ufr_cmd_fifo #(
    .WIDTH (CMDW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_data),
    .pop   (cmd_pop),
    .head  (cmd_head),
    .stat  (qstat)
  );

  ufr_back #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT),
    .COUNT_BITS      (COUNT_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (cmd_head),
    .q_empty           (qstat.empty),
    .q_pop             (cmd_pop),
    .out_byte          (out_byte),
    .out_is_terminator (out_is_terminator),
    .out_last          (out_last),
    .out_replace_count (out_replace_count),
    .empty             (empty),
    .pop               (pop)
  );

endmodule

`default_nettype wire

// ----- design/ufr_checker.sv -----
// Port-level checks on the result channel of utf8_find_and_replace, bound to the top.
// Depends on ufr_pkg (result count width).
`timescale 1ns / 1ps
`default_nettype none

module ufr_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        empty,
  input wire logic                        pop,
  input wire logic [7:0]                  out_byte,
  input wire logic                        out_is_terminator,
  input wire logic                        out_last,
  input wire logic [ufr_pkg::RC_W-1:0]    out_replace_count
);

  a_term_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_is_terminator) |-> (out_byte == 8'h00 && out_last))
    else $error("terminator beat must carry a zero byte and close its item");

  a_count_on_term_only: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_is_terminator) |-> (out_replace_count == '0))
    else $error("replacement count shown on a text beat");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_is_terminator) &&
                          $stable(out_last) && $stable(out_replace_count)))
    else $error("stalled result changed or vanished");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result queue not empty after reset");

endmodule

bind utf8_find_and_replace ufr_checker u_ufr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .empty             (empty),
  .pop               (pop),
  .out_byte          (out_byte),
  .out_is_terminator (out_is_terminator),
  .out_last          (out_last),
  .out_replace_count (out_replace_count)
);

`default_nettype wire
